[rtl/sample_to_volume_code_packer_core_assert.svh]
// Assertion macros for the sample to volume code packer core.
// The enclosing module must provide clk and rst_n.
`ifndef SAMPLE_TO_VOLUME_CODE_PACKER_CORE_ASSERT_SVH
`define SAMPLE_TO_VOLUME_CODE_PACKER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define SVCP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SVCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SVCP_ASSERT_SAME(lbl, ante, cons, msg)
`define SVCP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/svcp_pkg.sv]
`timescale 1ns / 1ps
package svcp_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int CODE_W     = 4;
  localparam int NUM_THR    = 15;
  localparam int THM_W      = 1 << CODE_W;
  localparam int MARGIN_W   = 7;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int LANES      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [PROD_W-1:0]     prod_t;
  typedef logic [CODE_W-1:0]     code_t;
  typedef logic [MARGIN_W-1:0]   margin_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_CLIP_MARGIN  = 2'd0;
  localparam cfg_idx_t CFG_LOG_SCALE    = 2'd1;
  localparam cfg_idx_t CFG_INVERT_CODES = 2'd2;

  localparam margin_t CLIP_MARGIN_RST  = 7'd32;
  localparam logic    LOG_SCALE_RST    = 1'b1;
  localparam logic    INVERT_CODES_RST = 1'b0;

  localparam sample_t FULL_SCALE = 8'hFF;
  localparam sample_t LIN_TOP    = 8'hF8;

  typedef struct packed {
    margin_t clip_margin;
    logic    log_scale;
    logic    invert_codes;
  } cfg_t;

  localparam sample_t LOG_THR [NUM_THR] = '{
    8'd228, 8'd181, 8'd143, 8'd114, 8'd90, 8'd72, 8'd57, 8'd45,
    8'd36, 8'd28, 8'd22, 8'd18, 8'd14, 8'd11, 8'd5
  };

  function automatic sample_t thr_of(input logic log_sel, input code_t k);
    sample_t t;
    if (log_sel) begin
      t = LOG_THR[k];
    end else begin
      t = LIN_TOP - {k, 4'b0000};
    end
    return t;
  endfunction

  function automatic sample_t span_of(input margin_t m);
    return FULL_SCALE - {m, 1'b0};
  endfunction

endpackage

[rtl/svcp_clip.sv]
`timescale 1ns / 1ps
module svcp_clip (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  svcp_pkg::cfg_t                           cfg_i,
  input  logic                                     up_vld_i,
  output logic                                     up_rdy_o,
  input  svcp_pkg::sample_t [svcp_pkg::LANES-1:0]  smp_i,
  output logic                                     dn_vld_o,
  input  logic                                     dn_rdy_i,
  output svcp_pkg::sample_t [svcp_pkg::LANES-1:0]  ofs_o
);

  logic                                    vld_r;
  svcp_pkg::sample_t [svcp_pkg::LANES-1:0] ofs_r;
  svcp_pkg::sample_t [svcp_pkg::LANES-1:0] ofs_nxt;
  svcp_pkg::sample_t                       lo;
  svcp_pkg::sample_t                       hi;
  svcp_pkg::sample_t                       clp;

  assign up_rdy_o = !vld_r || dn_rdy_i;
  assign dn_vld_o = vld_r;
  assign ofs_o    = ofs_r;

  // clamp to [m, 255-m] and drop the margin
  always_comb begin
    lo  = {1'b0, cfg_i.clip_margin};
    hi  = svcp_pkg::FULL_SCALE - lo;
    clp = '0;
    for (int l = 0; l < svcp_pkg::LANES; l++) begin
      if (smp_i[l] < lo) begin
        clp = lo;
      end else if (smp_i[l] > hi) begin
        clp = hi;
      end else begin
        clp = smp_i[l];
      end
      ofs_nxt[l] = clp - lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy_o) begin
      vld_r <= up_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy_o && up_vld_i) begin
      ofs_r <= ofs_nxt;
    end
  end

endmodule

[rtl/svcp_scale.sv]
`timescale 1ns / 1ps
module svcp_scale (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     up_vld_i,
  output logic                                     up_rdy_o,
  input  svcp_pkg::sample_t [svcp_pkg::LANES-1:0]  ofs_i,
  output logic                                     dn_vld_o,
  input  logic                                     dn_rdy_i,
  output svcp_pkg::prod_t [svcp_pkg::LANES-1:0]    scl_o
);

  logic                                  vld_r;
  svcp_pkg::prod_t [svcp_pkg::LANES-1:0] scl_r;
  svcp_pkg::prod_t [svcp_pkg::LANES-1:0] scl_nxt;

  assign up_rdy_o = !vld_r || dn_rdy_i;
  assign dn_vld_o = vld_r;
  assign scl_o    = scl_r;

  // x * 255 as (x << 8) - x
  always_comb begin
    for (int l = 0; l < svcp_pkg::LANES; l++) begin
      scl_nxt[l] = {ofs_i[l], {svcp_pkg::SAMPLE_W{1'b0}}}
                 - {{svcp_pkg::SAMPLE_W{1'b0}}, ofs_i[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy_o) begin
      vld_r <= up_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy_o && up_vld_i) begin
      scl_r <= scl_nxt;
    end
  end

endmodule

[rtl/svcp_quant.sv]
`timescale 1ns / 1ps
module svcp_quant (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  svcp_pkg::cfg_t                           cfg_i,
  input  logic                                     up_vld_i,
  output logic                                     up_rdy_o,
  input  svcp_pkg::prod_t [svcp_pkg::LANES-1:0]    scl_i,
  output logic                                     dn_vld_o,
  input  logic                                     dn_rdy_i,
  output svcp_pkg::code_t [svcp_pkg::LANES-1:0]    code_o
);

  logic                                  vld_r;
  svcp_pkg::code_t [svcp_pkg::LANES-1:0] code_r;
  svcp_pkg::code_t [svcp_pkg::LANES-1:0] code_nxt;
  svcp_pkg::prod_t                       prod_r [svcp_pkg::NUM_THR];
  svcp_pkg::prod_t                       prod_nxt [svcp_pkg::NUM_THR];
  svcp_pkg::sample_t                     span;
  svcp_pkg::sample_t                     thr;
  logic [svcp_pkg::THM_W-1:0]            thm [svcp_pkg::LANES];

  assign up_rdy_o = !vld_r || dn_rdy_i;
  assign dn_vld_o = vld_r;
  assign code_o   = code_r;

  // threshold * span, so t > floor(255x/span) becomes 255x < t*span
  always_comb begin
    span = svcp_pkg::span_of(cfg_i.clip_margin);
    thr  = '0;
    for (int k = 0; k < svcp_pkg::NUM_THR; k++) begin
      thr         = svcp_pkg::thr_of(cfg_i.log_scale, svcp_pkg::CODE_W'(k));
      prod_nxt[k] = {{svcp_pkg::SAMPLE_W{1'b0}}, thr}
                  * {{svcp_pkg::SAMPLE_W{1'b0}}, span};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < svcp_pkg::NUM_THR; k++) begin
      prod_r[k] <= prod_nxt[k];
    end
  end

  // products fall with k, so the hits form a thermometer; binary-search its length
  always_comb begin
    for (int l = 0; l < svcp_pkg::LANES; l++) begin
      thm[l] = '0;
      for (int k = 0; k < svcp_pkg::NUM_THR; k++) begin
        thm[l][k] = scl_i[l] < prod_r[k];
      end
      code_nxt[l][3] = thm[l][7];
      code_nxt[l][2] = thm[l][{code_nxt[l][3], 3'b011}];
      code_nxt[l][1] = thm[l][{code_nxt[l][3], code_nxt[l][2], 2'b01}];
      code_nxt[l][0] = thm[l][{code_nxt[l][3], code_nxt[l][2], code_nxt[l][1], 1'b0}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy_o) begin
      vld_r <= up_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy_o && up_vld_i) begin
      code_r <= code_nxt;
    end
  end

endmodule

[rtl/sample_to_volume_code_packer_core.sv]
`timescale 1ns / 1ps
// Channel  Handshake               Payload
// in       in_tvalid / in_tready   in_tdata  : one sample pair
// out      out_tvalid / out_tready out_tdata : packed codes
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One sample pair per cycle while out_tready is high; four register stages (clip, scale, threshold
// compare, pack) lie between a request and its result.
// Reset is synchronous, active low: clears all stage valids and loads
// margin 32, log scale, codes not inverted. cfg_ready is always high.
// Each stage holds while the next is full and stalled; empty stages fill.
module sample_to_volume_code_packer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [7:0] first_sample, [15:8] second_sample
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] packed_codes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  svcp_pkg::cfg_idx_t            cfg_index,
  input  svcp_pkg::cfg_data_t           cfg_data
);

  `include "sample_to_volume_code_packer_core_assert.svh"

  svcp_pkg::cfg_t                          cfg_r;
  svcp_pkg::cfg_t                          cfg_nxt;
  svcp_pkg::sample_t [svcp_pkg::LANES-1:0] smp;
  svcp_pkg::sample_t [svcp_pkg::LANES-1:0] s1_ofs;
  svcp_pkg::prod_t [svcp_pkg::LANES-1:0]   s2_scl;
  svcp_pkg::code_t [svcp_pkg::LANES-1:0]   s3_code;
  logic                                    s1_vld;
  logic                                    s1_rdy;
  logic                                    s2_vld;
  logic                                    s2_rdy;
  logic                                    s3_vld;
  logic                                    s3_rdy;
  logic                                    out_vld_r;
  logic [7:0]                              out_data_r;
  logic [7:0]                              out_data_nxt;
  svcp_pkg::code_t                         inv_mask;
  svcp_pkg::sample_t                       span;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        svcp_pkg::CFG_CLIP_MARGIN:  cfg_nxt.clip_margin  = cfg_data;
        svcp_pkg::CFG_LOG_SCALE:    cfg_nxt.log_scale    = cfg_data[0];
        svcp_pkg::CFG_INVERT_CODES: cfg_nxt.invert_codes = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_margin  <= svcp_pkg::CLIP_MARGIN_RST;
      cfg_r.log_scale    <= svcp_pkg::LOG_SCALE_RST;
      cfg_r.invert_codes <= svcp_pkg::INVERT_CODES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign smp[0] = in_tdata[7:0];
  assign smp[1] = in_tdata[15:8];

  svcp_clip u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg_r),
    .up_vld_i (in_tvalid),
    .up_rdy_o (in_tready),
    .smp_i    (smp),
    .dn_vld_o (s1_vld),
    .dn_rdy_i (s1_rdy),
    .ofs_o    (s1_ofs)
  );

  svcp_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld_i (s1_vld),
    .up_rdy_o (s1_rdy),
    .ofs_i    (s1_ofs),
    .dn_vld_o (s2_vld),
    .dn_rdy_i (s2_rdy),
    .scl_o    (s2_scl)
  );

  svcp_quant u_quant (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg_r),
    .up_vld_i (s2_vld),
    .up_rdy_o (s2_rdy),
    .scl_i    (s2_scl),
    .dn_vld_o (s3_vld),
    .dn_rdy_i (s3_rdy),
    .code_o   (s3_code)
  );

  // first sample to the high nibble
  assign inv_mask     = {svcp_pkg::CODE_W{cfg_r.invert_codes}};
  assign out_data_nxt = {s3_code[0] ^ inv_mask, s3_code[1] ^ inv_mask};
  assign s3_rdy       = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s3_rdy) begin
      out_vld_r <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s3_vld) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  assign span = svcp_pkg::span_of(cfg_r.clip_margin);

  `SVCP_ASSERT_SAME(a_ofs_in_span, s1_vld, (span != '0) && (s1_ofs[0] <= span) && (s1_ofs[1] <= span), "clipped offset exceeds span")
  `SVCP_ASSERT_SAME(a_scl_range, s2_vld, (s2_scl[0] <= 16'd65025) && (s2_scl[1] <= 16'd65025), "scaled value out of range")
  `SVCP_ASSERT_NEXT(a_cfg_unknown_idx, cfg_valid && cfg_ready && (cfg_index != svcp_pkg::CFG_CLIP_MARGIN) && (cfg_index != svcp_pkg::CFG_LOG_SCALE) && (cfg_index != svcp_pkg::CFG_INVERT_CODES), $stable(cfg_r), "write to unknown index changed config")
  `SVCP_ASSERT_NEXT(a_latency, (in_tvalid && in_tready) ##1 out_tready ##1 out_tready ##1 out_tready, out_tvalid, "request did not reach output in four cycles")

endmodule

[sim/tb_sample_to_volume_code_packer_core.sv]
`timescale 1ns / 1ps
module tb_sample_to_volume_code_packer_core;

  localparam svcp_pkg::cfg_idx_t REG_UNUSED = 2'd3;

  class code_scoreboard;
    int unsigned margin;
    bit          log_sel;
    bit          invert;
    int unsigned log_steps [15];
    logic [7:0]  code_q [$];
    int          errors;

    function new();
      margin    = 32;
      log_sel   = 1'b1;
      invert    = 1'b0;
      errors    = 0;
      log_steps = '{228, 181, 143, 114, 90, 72, 57, 45, 36, 28, 22, 18, 14, 11, 5};
    endfunction

    function void write_reg(svcp_pkg::cfg_idx_t idx, svcp_pkg::cfg_data_t val);
      case (idx)
        svcp_pkg::CFG_CLIP_MARGIN:  margin  = val;
        svcp_pkg::CFG_LOG_SCALE:    log_sel = val[0];
        svcp_pkg::CFG_INVERT_CODES: invert  = val[0];
        default: ;
      endcase
    endfunction

    function logic [3:0] level_code(logic [7:0] s);
      int unsigned c;
      int unsigned v;
      int unsigned n;
      int unsigned thr;
      c = s;
      if (c < margin) c = margin;
      if (c > 255 - margin) c = 255 - margin;
      v = (c - margin) * 255 / (255 - 2 * margin);
      n = 0;
      for (int k = 0; k < 15; k++) begin
        thr = log_sel ? log_steps[k] : 248 - 16 * k;
        if (thr > v) n++;
      end
      if (invert) n = n ^ 15;
      return n[3:0];
    endfunction

    function void note_request(logic [15:0] pair);
      code_q.push_back({level_code(pair[7:0]), level_code(pair[15:8])});
    endfunction

    function void check_result(logic [7:0] got);
      logic [7:0] want;
      if (code_q.size() == 0) begin
        $display("%0t: unexpected packed codes %02h", $time, got);
        errors++;
      end else begin
        want = code_q.pop_front();
        if (got !== want) begin
          $display("%0t: packed codes expected %02h, got %02h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return code_q.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_tvalid;
  logic      in_tready;
  logic [15:0] in_tdata;
  logic      out_tvalid;
  logic      out_tready;
  logic [7:0] out_tdata;
  logic      cfg_valid;
  logic      cfg_ready;
  svcp_pkg::cfg_idx_t  cfg_index;
  svcp_pkg::cfg_data_t cfg_data;

  code_scoreboard sb;
  int src_idle_pct;
  int sink_idle_pct;
  int stall_reqs;
  int stall_seen;
  int hold_left;

  sample_to_volume_code_packer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  = hold_left - 1;
    end else if (stall_seen != stall_reqs) begin
      stall_seen = stall_reqs;
      hold_left  = 79;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  task automatic send_pair(logic [7:0] first, logic [7:0] second);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {second, first};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(svcp_pkg::cfg_idx_t idx, svcp_pkg::cfg_data_t val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [7:0] pick_sample();
    int unsigned m;
    m = sb.margin;
    case ($urandom_range(5))
      0: return 8'(m + $urandom_range(2) + 255);
      1: return 8'(255 - m + $urandom_range(2) + 255);
      2: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int unsigned m;
    sb            = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = svcp_pkg::CFG_CLIP_MARGIN;
    cfg_data      = '0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    stall_reqs    = 0;
    stall_seen    = 0;
    hold_left     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: margin edges and full scale
    send_pair(8'd0, 8'd255);
    send_pair(8'd255, 8'd0);
    send_pair(8'd31, 8'd32);
    send_pair(8'd223, 8'd224);
    send_pair(8'd128, 8'd127);
    send_pair(8'd85, 8'd170);
    // zero margin: identity rescale, log threshold edges
    write_reg(svcp_pkg::CFG_CLIP_MARGIN, 7'd0);
    send_pair(8'd228, 8'd227);
    send_pair(8'd5, 8'd4);
    send_pair(8'd11, 8'd10);
    // linear scale, upper data bits dropped
    write_reg(svcp_pkg::CFG_LOG_SCALE, 7'h7E);
    send_pair(8'd248, 8'd247);
    send_pair(8'd24, 8'd23);
    send_pair(8'd0, 8'd255);
    write_reg(svcp_pkg::CFG_INVERT_CODES, 7'h7F);
    send_pair(8'd0, 8'd255);
    send_pair(8'd128, 8'd64);
    write_reg(REG_UNUSED, 7'($urandom_range(127)));
    send_pair(8'd200, 8'd16);
    // widest margin: span of one
    write_reg(svcp_pkg::CFG_CLIP_MARGIN, 7'd127);
    send_pair(8'd126, 8'd127);
    send_pair(8'd128, 8'd129);
    write_reg(svcp_pkg::CFG_CLIP_MARGIN, 7'd1);
    send_pair(8'd1, 8'd254);
    send_pair(8'd0, 8'd255);

    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      src_idle_pct  = (ph == 0) ? 19 : (ph == 1) ? 78 : 0;
      sink_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 19 : 0;
      for (int s = 0; s < 4; s++) begin
        m = (s == 0) ? 0 : (s == 1) ? 127 : $urandom_range(127);
        write_reg(svcp_pkg::CFG_CLIP_MARGIN, 7'(m));
        write_reg(svcp_pkg::CFG_LOG_SCALE, {6'($urandom_range(63)), s[0]});
        write_reg(svcp_pkg::CFG_INVERT_CODES, {6'($urandom_range(63)), s[1] ^ ph[0]});
        // hold the receiver off while requests keep coming
        if (ph == 2 && s == 0) stall_reqs <= stall_reqs + 1;
        repeat (70) send_pair(pick_sample(), pick_sample());
      end
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("sample_to_volume_code_packer_core: match");
    end else begin
      $display("sample_to_volume_code_packer_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("sample_to_volume_code_packer_core: mismatch");
    $finish;
  end
endmodule
